FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every edge out of reset
`define SFD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// consequent must hold at the edge after the antecedent
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SFD_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// types and constants of the symmetric i/q fir decimator
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int MAX_HALF_LENGTH    = 32;
  localparam int NORMAL_HALF_LENGTH = 16;
  localparam int SAMPLE_BITS        = 16;
  localparam int COEF_BITS          = 16;
  localparam int HIST_DEPTH         = 2 * MAX_HALF_LENGTH + 1;
  localparam int COEF_DEPTH         = MAX_HALF_LENGTH + 1;
  localparam int COEF_AW            = $clog2(COEF_DEPTH);
  localparam int STEP_W             = $clog2(HIST_DEPTH + 1);
  localparam int HALF_W             = 6;
  localparam int BASE_SHIFT         = 13;
  localparam int MAX_STRIDE         = 8;
  localparam int PROD_W             = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W              = PROD_W + $clog2(HIST_DEPTH);
  localparam int OUT_MAX            = 32767;
  localparam int OUT_MIN            = -32768;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // input word kinds
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_CLEAR = 2'd2
  } sfd_kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_HALF_LENGTH = 2'd0;
  localparam logic [1:0] REG_WIDE_MODE   = 2'd1;
  localparam logic [1:0] REG_SCALING     = 2'd2;
  localparam logic [1:0] REG_STRIDE      = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } sfd_state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] i;
    logic signed [SAMPLE_BITS-1:0] q;
  } sample_t;

  // control travelling with each tap through the mac pipeline
  typedef struct packed {
    logic valid;
    logic tap_ok;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

FILE: rtl/sfd_in_if.sv
// ----------------------------------------------------------------------------
// sfd_in_if
// input channel: coefficient loads, sample pushes and clears
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  coef_index;
  logic signed [15:0] coef_value;
  logic signed [15:0] sample_i;
  logic signed [15:0] sample_q;

  modport source (output valid, kind, coef_index, coef_value, sample_i, sample_q,
                  input ready);
  modport sink   (input valid, kind, coef_index, coef_value, sample_i, sample_q,
                  output ready);
endinterface

FILE: rtl/sfd_out_if.sv
// ----------------------------------------------------------------------------
// sfd_out_if
// result channel: filtered i/q pair
// ----------------------------------------------------------------------------
interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] out_i;
  logic signed [15:0] out_q;

  modport source (output valid, out_i, out_q, input ready);
  modport sink   (input valid, out_i, out_q, output ready);
endinterface

FILE: rtl/sfd_cfg_if.sv
// ----------------------------------------------------------------------------
// sfd_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface sfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [5:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/sfd_ram.sv
// ----------------------------------------------------------------------------
// sfd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/sfd_cell.sv
// ----------------------------------------------------------------------------
// sfd_cell
// one history cell of the delay chain, holds one i/q sample
// ----------------------------------------------------------------------------
module sfd_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             shift,
  input  sfd_pkg::sample_t d,
  output sfd_pkg::sample_t q
);

  sfd_pkg::sample_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/sfd_mac.sv
// ----------------------------------------------------------------------------
// sfd_mac
// pipelined i/q multiply-accumulate with final scale and saturation
// ----------------------------------------------------------------------------
module sfd_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sfd_pkg::mac_ctl_t                   ctl,
  input  sfd_pkg::sample_t                    smp,
  input  logic [sfd_pkg::COEF_BITS-1:0]       coef,
  input  logic [3:0]                          scaling,
  input  logic                                take,
  output logic                                res_valid,
  output sfd_pkg::sample_t                    res
);

  sfd_pkg::mac_ctl_t ctl1_r, ctl2_r;
  sfd_pkg::sample_t  smp1_r;
  sfd_pkg::prod_t    prod_i_r, prod_q_r, prod_i_nxt, prod_q_nxt;
  sfd_pkg::acc_t     acc_i_r, acc_q_r;
  logic              res_valid_r;
  logic signed [sfd_pkg::SAMPLE_BITS-1:0] s_i, s_q;
  logic signed [sfd_pkg::COEF_BITS-1:0]   c_s;
  logic [5:0]        shamt;

  function automatic logic signed [15:0] sat16(sfd_pkg::acc_t v);
    logic signed [15:0] r;
    if (v > sfd_pkg::acc_t'(sfd_pkg::OUT_MAX)) begin
      r = 16'sh7fff;
    end else if (v < sfd_pkg::acc_t'(sfd_pkg::OUT_MIN)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // stage 1: align sample with registered coefficient read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    smp1_r <= smp;
  end

  // stage 2: products, taps outside the window add nothing
  always_comb begin
    s_i = smp1_r.i;
    s_q = smp1_r.q;
    c_s = $signed(coef);
    if (ctl1_r.valid && ctl1_r.tap_ok) begin
      prod_i_nxt = s_i * c_s;
      prod_q_nxt = s_q * c_s;
    end else begin
      prod_i_nxt = '0;
      prod_q_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    prod_i_r <= prod_i_nxt;
    prod_q_r <= prod_q_nxt;
  end

  // stage 3: accumulate
  always_ff @(posedge clk) begin
    if (ctl2_r.valid) begin
      if (ctl2_r.first) begin
        acc_i_r <= sfd_pkg::acc_t'(prod_i_r);
        acc_q_r <= sfd_pkg::acc_t'(prod_q_r);
      end else begin
        acc_i_r <= acc_i_r + sfd_pkg::acc_t'(prod_i_r);
        acc_q_r <= acc_q_r + sfd_pkg::acc_t'(prod_q_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (ctl2_r.valid && ctl2_r.last) begin
      res_valid_r <= 1'b1;
    end else if (take) begin
      res_valid_r <= 1'b0;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign shamt     = 6'(sfd_pkg::BASE_SHIFT) + 6'(scaling);
  assign res.i     = sat16(acc_i_r >>> shamt);
  assign res.q     = sat16(acc_q_r >>> shamt);
  assign res_valid = res_valid_r;

endmodule

FILE: rtl/symmetric_iq_fir_decimator.sv
// ----------------------------------------------------------------------------
// symmetric_iq_fir_decimator
// linear-phase fir decimator over complex i/q samples
// ----------------------------------------------------------------------------
// in_ch takes words of three kinds: a coefficient load (coef_index 0..32),
// a sample push and a history clear. loads, clears and pushes that give no
// result leave in_ch ready. out_ch gives one filtered i/q word for every
// output_stride pushes, counting from reset or clear and including the first.
// cfg_ch writes half_length_code, wide_mode, scaling and output_stride; it
// is always ready and is meant to be written while the block is idle.
// the history is a chain of 65 cells. a push shifts the new sample in at the
// head; a filter pass rotates the whole chain once round while the mac sees
// the tail cell. a pushing word that emits is therefore busy for the rotation,
// the mac pipeline and the wait for the output register, and in_ch takes no
// new word until the result has moved into that register. the rotation of
// the chain sets the rate of emitting pushes while out_ch does not stall. an
// output_stride of 0 acts as 1, and one above 8 acts as 8.
// the result sits in an output register: while it waits the block keeps
// taking words, and a second pass only ends when that register is free.
// reset zeroes the history, the stride phase and the registers (stride 1);
// coefficients are undefined until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module symmetric_iq_fir_decimator (
  input  logic       clk,
  input  logic       rst_n,
  sfd_in_if.sink     in_ch,
  sfd_out_if.source  out_ch,
  sfd_cfg_if.sink    cfg_ch
);

  localparam logic [sfd_pkg::STEP_W-1:0] LAST_STEP =
    sfd_pkg::STEP_W'(sfd_pkg::HIST_DEPTH - 1);

  // configuration registers
  logic [5:0] half_code_r;
  logic       wide_r;
  logic [3:0] scaling_r;
  logic [3:0] stride_r;

  // control
  sfd_pkg::sfd_state_t         state_r, state_nxt;
  logic [sfd_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [2:0]                  phase_r, phase_nxt;

  logic in_acc, is_load, is_push, is_clear, emit;
  logic [3:0] stride_eff, phase_inc;

  // window arithmetic
  logic [sfd_pkg::HALF_W-1:0] limit, half;
  logic [sfd_pkg::STEP_W-1:0] two_h, k, ci;
  logic                       tap_ok;

  // delay chain
  sfd_pkg::sample_t cell_q [sfd_pkg::HIST_DEPTH];
  sfd_pkg::sample_t head_d, new_smp;
  logic             shift;

  // mac and output register
  sfd_pkg::mac_ctl_t           mac_ctl;
  logic [sfd_pkg::COEF_BITS-1:0] coef_rd;
  logic                        res_valid, take;
  sfd_pkg::sample_t            res;
  logic                        out_valid_r;
  logic signed [15:0]          out_i_r, out_q_r;

  // --------------------------------------------------------------------------
  // input decode
  // --------------------------------------------------------------------------
  assign in_ch.ready = (state_r == sfd_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_load     = in_acc && (in_ch.kind == sfd_pkg::KIND_LOAD);
  assign is_push     = in_acc && (in_ch.kind == sfd_pkg::KIND_PUSH);
  assign is_clear    = in_acc && (in_ch.kind == sfd_pkg::KIND_CLEAR);

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_code_r <= '0;
      wide_r      <= 1'b0;
      scaling_r   <= '0;
      stride_r    <= 4'd1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        sfd_pkg::REG_HALF_LENGTH: half_code_r <= cfg_ch.data;
        sfd_pkg::REG_WIDE_MODE:   wide_r      <= cfg_ch.data[0];
        sfd_pkg::REG_SCALING:     scaling_r   <= cfg_ch.data[3:0];
        sfd_pkg::REG_STRIDE:      stride_r    <= cfg_ch.data[3:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // decimation phase: a result is due when the phase is zero
  // --------------------------------------------------------------------------
  always_comb begin
    if (stride_r == 4'd0) begin
      stride_eff = 4'd1;
    end else if (stride_r > 4'(sfd_pkg::MAX_STRIDE)) begin
      stride_eff = 4'(sfd_pkg::MAX_STRIDE);
    end else begin
      stride_eff = stride_r;
    end
    phase_inc = {1'b0, phase_r} + 4'd1;
    phase_nxt = phase_r;
    if (is_clear) begin
      phase_nxt = '0;
    end else if (is_push) begin
      phase_nxt = (phase_inc >= stride_eff) ? 3'd0 : phase_inc[2:0];
    end
  end

  assign emit = is_push && (phase_r == 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer: idle, rotate the chain once round, wait for the result
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfd_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      sfd_pkg::ST_IDLE: begin
        if (emit) begin
          state_nxt = sfd_pkg::ST_RUN;
          step_nxt  = '0;
        end
      end
      sfd_pkg::ST_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = sfd_pkg::ST_WAIT;
        end
      end
      sfd_pkg::ST_WAIT: begin
        if (take) begin
          state_nxt = sfd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sfd_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // tap window: the tail cell at step s holds the sample s pushes back from
  // the oldest, i.e. age k = 64 - s; taps are ages 0..2h, mirrored about h
  // --------------------------------------------------------------------------
  always_comb begin
    limit  = wide_r ? sfd_pkg::HALF_W'(sfd_pkg::MAX_HALF_LENGTH)
                    : sfd_pkg::HALF_W'(sfd_pkg::NORMAL_HALF_LENGTH);
    half   = (half_code_r > limit) ? limit : half_code_r;
    two_h  = {half, 1'b0};
    k      = LAST_STEP - step_r;
    tap_ok = (k <= two_h);
    ci     = (k < {1'b0, half}) ? k : (two_h - k);
  end

  // --------------------------------------------------------------------------
  // coefficient table
  // --------------------------------------------------------------------------
  sfd_ram #(
    .WIDTH (sfd_pkg::COEF_BITS),
    .DEPTH (sfd_pkg::COEF_DEPTH)
  ) u_coef (
    .clk   (clk),
    .we    (is_load && (in_ch.coef_index < 6'(sfd_pkg::COEF_DEPTH))),
    .waddr (in_ch.coef_index[sfd_pkg::COEF_AW-1:0]),
    .wdata (in_ch.coef_value),
    .re    ((state_r == sfd_pkg::ST_RUN) && tap_ok),
    .raddr (ci[sfd_pkg::COEF_AW-1:0]),
    .rdata (coef_rd)
  );

  // --------------------------------------------------------------------------
  // history chain: push shifts the new word in, a pass rotates tail to head
  // --------------------------------------------------------------------------
  assign new_smp.i = in_ch.sample_i;
  assign new_smp.q = in_ch.sample_q;
  assign shift     = is_push || (state_r == sfd_pkg::ST_RUN);
  assign head_d    = (state_r == sfd_pkg::ST_RUN) ? cell_q[sfd_pkg::HIST_DEPTH-1] : new_smp;

  for (genvar j = 0; j < sfd_pkg::HIST_DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_head
      sfd_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (is_clear),
        .shift (shift),
        .d     (head_d),
        .q     (cell_q[j])
      );
    end else begin : g_body
      sfd_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (is_clear),
        .shift (shift),
        .d     (cell_q[j-1]),
        .q     (cell_q[j])
      );
    end
  end

  // --------------------------------------------------------------------------
  // multiply-accumulate
  // --------------------------------------------------------------------------
  assign mac_ctl.valid  = (state_r == sfd_pkg::ST_RUN);
  assign mac_ctl.tap_ok = tap_ok;
  assign mac_ctl.first  = (step_r == '0);
  assign mac_ctl.last   = (step_r == LAST_STEP);

  sfd_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .smp       (cell_q[sfd_pkg::HIST_DEPTH-1]),
    .coef      (coef_rd),
    .scaling   (scaling_r),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  assign take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_i_r <= res.i;
      out_q_r <= res.q;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_i = out_i_r;
  assign out_ch.out_q = out_q_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `SFD_ASSERT_NEXT(a_run_ends_in_wait, clk, rst_n,
    (state_r == sfd_pkg::ST_RUN) && (step_r == LAST_STEP), state_r == sfd_pkg::ST_WAIT)
  `SFD_ASSERT_ALWAYS(a_result_only_in_wait, clk, rst_n,
    !res_valid || (state_r == sfd_pkg::ST_WAIT))
  `SFD_ASSERT_NEXT(a_clear_resets_phase, clk, rst_n, is_clear, phase_r == 3'd0)

endmodule

FILE: verif/tb_symmetric_iq_fir_decimator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_symmetric_iq_fir_decimator
// self-checking bench for the symmetric i/q fir decimator
// ----------------------------------------------------------------------------
// all 33 coefficients are loaded first. a short directed run then covers
// saturation at both rails, ignored loads, the unused kind and clears. after
// that come eight phases of random words, each behind its own register
// setting: the extremes first, then random ones. a scoreboard class mirrors
// the filter, queues the i/q pair due for each emitting push and compares
// every word leaving out_ch with the oldest pair in the queue.
// ----------------------------------------------------------------------------
module tb_symmetric_iq_fir_decimator;

  localparam int         HALF_PERIOD   = 10;
  localparam int         RESET_CYCLES  = 12;
  localparam int         SETTLE_CYCLES = 100;  // one full pass plus margin
  localparam int         HOLD_CYCLES   = 400;  // long hold-off on out_ch
  localparam int         PHASES        = 8;
  localparam int         PHASE_WORDS   = 125;
  localparam logic [1:0] KIND_UNUSED   = 2'd3; // no defined meaning, ignored

  // one word on in_ch, as seen at the handshake
  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         idx;
    logic signed [15:0] cval;
    logic signed [15:0] si;
    logic signed [15:0] sq;
  } in_word_t;

  typedef struct {
    logic signed [15:0] i;
    logic signed [15:0] q;
  } iq_pair_t;

  // mirror of the filter: registers, history ring, coefficients and the
  // queue of i/q pairs still owed on out_ch
  class iq_fir_tracker;
    logic [5:0]         half_code;
    logic               wide;
    logic [3:0]         shift_extra;
    logic [3:0]         stride_reg;
    logic signed [15:0] hist_i [sfd_pkg::HIST_DEPTH];
    logic signed [15:0] hist_q [sfd_pkg::HIST_DEPTH];
    logic signed [15:0] coefs [sfd_pkg::COEF_DEPTH];
    int                 head;
    int                 phase;
    iq_pair_t           pending_iq [$];
    int                 errors;

    function new();
      half_code   = '0;
      wide        = 1'b0;
      shift_extra = '0;
      stride_reg  = 4'd1;
      errors      = 0;
      foreach (coefs[k]) coefs[k] = '0;
      wipe();
    endfunction

    function void wipe();
      foreach (hist_i[k]) begin
        hist_i[k] = '0;
        hist_q[k] = '0;
      end
      head  = 0;
      phase = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [5:0] data);
      case (idx)
        sfd_pkg::REG_HALF_LENGTH: half_code   = data;
        sfd_pkg::REG_WIDE_MODE:   wide        = data[0];
        sfd_pkg::REG_SCALING:     shift_extra = data[3:0];
        sfd_pkg::REG_STRIDE:      stride_reg  = data[3:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] clip(longint v);
      if (v > sfd_pkg::OUT_MAX) return 16'sh7fff;
      if (v < sfd_pkg::OUT_MIN) return 16'sh8000;
      return v[15:0];
    endfunction

    // mirrored table over the newest 2h+1 samples, floor shift, saturate
    function iq_pair_t filter_output();
      int       limit;
      int       h;
      int       taps;
      int       hi;
      int       ci;
      int       sh;
      longint   acc_i;
      longint   acc_q;
      iq_pair_t r;
      limit = wide ? sfd_pkg::MAX_HALF_LENGTH : sfd_pkg::NORMAL_HALF_LENGTH;
      h     = (half_code > limit) ? limit : half_code;
      taps  = 2 * h + 1;
      acc_i = 0;
      acc_q = 0;
      for (int t = 0; t < taps; t++) begin
        hi    = (head + sfd_pkg::HIST_DEPTH - taps + t) % sfd_pkg::HIST_DEPTH;
        ci    = (t <= h) ? t : (taps - t - 1);
        acc_i += longint'(hist_i[hi]) * longint'(coefs[ci]);
        acc_q += longint'(hist_q[hi]) * longint'(coefs[ci]);
      end
      sh  = sfd_pkg::BASE_SHIFT + shift_extra;
      r.i = clip(acc_i >>> sh);
      r.q = clip(acc_q >>> sh);
      return r;
    endfunction

    function void take_word(in_word_t w);
      int  s;
      int  nxt;
      bit  emit;
      case (w.kind)
        sfd_pkg::KIND_LOAD: begin
          if (w.idx <= sfd_pkg::MAX_HALF_LENGTH) coefs[w.idx] = w.cval;
        end
        sfd_pkg::KIND_CLEAR: wipe();
        sfd_pkg::KIND_PUSH: begin
          emit         = (phase == 0);
          hist_i[head] = w.si;
          hist_q[head] = w.sq;
          head         = (head + 1) % sfd_pkg::HIST_DEPTH;
          s            = stride_reg;
          if (s == 0) s = 1;
          if (s > sfd_pkg::MAX_STRIDE) s = sfd_pkg::MAX_STRIDE;
          nxt   = phase + 1;
          phase = (nxt >= s) ? 0 : (nxt & 7);
          if (emit) pending_iq.push_back(filter_output());
        end
        default: ;
      endcase
    endfunction

    function void match_result(logic signed [15:0] got_i, logic signed [15:0] got_q);
      iq_pair_t want;
      if (pending_iq.size() == 0) begin
        errors++;
        $display("%0t: expected no result, got i=%0d q=%0d", $time, got_i, got_q);
        return;
      end
      want = pending_iq.pop_front();
      if (got_i !== want.i) begin
        errors++;
        $display("%0t: out_i expected %0d, got %0d", $time, want.i, got_i);
      end
      if (got_q !== want.q) begin
        errors++;
        $display("%0t: out_q expected %0d, got %0d", $time, want.q, got_q);
      end
    endfunction

    function void close();
      foreach (pending_iq[k]) begin
        errors++;
        $display("%0t: result never came, expected i=%0d q=%0d, got none", $time,
                 pending_iq[k].i, pending_iq[k].q);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();
  sfd_cfg_if cfg_ch ();

  symmetric_iq_fir_decimator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  iq_fir_tracker tracker = new();

  // idling switches per phase, and the request for the long hold-off
  bit src_idling;
  bit sink_idling;
  bit hold_req;
  int sink_stall;

  always #HALF_PERIOD clk = ~clk;

  // all handshakes are sampled here, at the rising edge; the bench only
  // drives on the falling edge so nothing here races with the drivers
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) tracker.set_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        tracker.take_word(in_word_t'{in_ch.kind, in_ch.coef_index, in_ch.coef_value,
                                     in_ch.sample_i, in_ch.sample_q});
      end
      if (out_ch.valid && out_ch.ready) tracker.match_result(out_ch.out_i, out_ch.out_q);
    end
  end

  // receiver: ready with random stall bursts, plus one long hold-off on
  // request while the sender keeps going, so the output register fills
  // and the block has to back-pressure in_ch
  initial begin
    out_ch.ready = 1'b0;
    sink_stall   = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        sink_stall = HOLD_CYCLES;
      end else if (sink_stall == 0 && sink_idling && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(1, 15);
      end
      if (sink_stall > 0) begin
        out_ch.ready <= 1'b0;
        sink_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // a 16-bit value: full range, small, rails or medium
  function automatic logic signed [15:0] pick16();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 2047) - 1024);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return 16'($urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  function automatic in_word_t mk(logic [1:0] kind, logic [5:0] idx, logic signed [15:0] cval,
                                  logic signed [15:0] si, logic signed [15:0] sq);
    return in_word_t'{kind, idx, cval, si, sq};
  endfunction

  // mostly pushes, some loads and clears, a few words the block drops;
  // counted is low for the dropped ones
  function automatic in_word_t random_word(output bit counted);
    in_word_t w;
    int       r;
    r      = $urandom_range(0, 99);
    w.cval = pick16();
    w.si   = pick16();
    w.sq   = pick16();
    w.idx  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                         : 6'($urandom_range(0, 32));
    if (r < 14)      w.kind = sfd_pkg::KIND_LOAD;
    else if (r < 19) w.kind = sfd_pkg::KIND_CLEAR;
    else if (r < 22) w.kind = KIND_UNUSED;
    else             w.kind = sfd_pkg::KIND_PUSH;
    counted = !(w.kind == KIND_UNUSED ||
                (w.kind == sfd_pkg::KIND_LOAD && w.idx > sfd_pkg::MAX_HALF_LENGTH));
    return w;
  endfunction

  // offer one word and hold it until taken; valid stays high into the
  // next word unless a gap follows
  task automatic offer(in_word_t w);
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= w.kind;
    in_ch.coef_index <= w.idx;
    in_ch.coef_value <= w.cval;
    in_ch.sample_i   <= w.si;
    in_ch.sample_q   <= w.sq;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic maybe_gap();
    int n;
    if (src_idling && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 15);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // stop sending, wait for every owed result, then wait SETTLE_CYCLES more
  // before touching the registers
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending_iq.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // junk fills the unused upper data bits, which the block should ignore
  task automatic write_config(logic [5:0] half, logic wide, logic [3:0] scale,
                              logic [3:0] stride, logic [5:0] junk);
    write_reg(sfd_pkg::REG_HALF_LENGTH, half);
    write_reg(sfd_pkg::REG_WIDE_MODE, {junk[5:1], wide});
    write_reg(sfd_pkg::REG_SCALING, {junk[5:4], scale});
    write_reg(sfd_pkg::REG_STRIDE, {junk[3:2], stride});
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    in_word_t   w;
    bit         counted;
    int         sent;
    logic [5:0] half;
    logic       wide;
    logic [3:0] scale;
    logic [3:0] stride;
    logic [5:0] junk;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = sfd_pkg::KIND_LOAD;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.sample_i   = '0;
    in_ch.sample_q   = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = sfd_pkg::REG_HALF_LENGTH;
    cfg_ch.data      = '0;
    src_idling       = 1'b0;
    sink_idling      = 1'b0;
    hold_req         = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // every coefficient gets a value before any pass can read it
    for (int k = 0; k < sfd_pkg::COEF_DEPTH; k++) begin
      offer(mk(sfd_pkg::KIND_LOAD, 6'(k), pick16(), '0, '0));
    end

    // directed run at reset settings: single tap, stride 1, base shift only
    offer(mk(sfd_pkg::KIND_LOAD, 6'd0, 16'sh8000, 16'sh1234, 16'sh4321));
    offer(mk(sfd_pkg::KIND_PUSH, 6'd63, 16'sh7fff, 16'sh7fff, 16'sh8000));  // both rails
    offer(mk(sfd_pkg::KIND_PUSH, 6'd0, 16'sh0000, 16'sh8000, 16'sh7fff));
    offer(mk(sfd_pkg::KIND_LOAD, 6'd0, 16'sh7fff, 16'sh0000, 16'sh0000));
    offer(mk(sfd_pkg::KIND_PUSH, 6'd0, 16'sh0000, 16'shffff, 16'sh0000));  // floor on negatives
    offer(mk(sfd_pkg::KIND_PUSH, 6'd0, 16'sh0000, 16'sh0001, 16'shffff));
    offer(mk(sfd_pkg::KIND_LOAD, 6'd33, 16'sh5555, 16'sh0000, 16'sh0000)); // index past table
    offer(mk(sfd_pkg::KIND_LOAD, 6'd63, 16'shaaaa, 16'sh7fff, 16'sh7fff));
    offer(mk(KIND_UNUSED, 6'h2a, 16'sh5a5a, 16'sha5a5, 16'sh5a5a));
    offer(mk(sfd_pkg::KIND_PUSH, 6'd0, 16'sh0000, 16'sh0000, 16'sh0000));
    offer(mk(sfd_pkg::KIND_CLEAR, 6'h15, 16'shffff, 16'shffff, 16'shffff));
    offer(mk(sfd_pkg::KIND_PUSH, 6'd0, 16'sh0000, 16'sh3039, 16'shcfc7));
    offer(mk(sfd_pkg::KIND_LOAD, 6'd0, 16'sh2000, 16'sh0000, 16'sh0000)); // unit gain
    offer(mk(sfd_pkg::KIND_PUSH, 6'd0, 16'sh0000, 16'sh8000, 16'sh7fff));
    offer(mk(sfd_pkg::KIND_PUSH, 6'd0, 16'sh0000, 16'sh5555, 16'shaaaa));
    offer(mk(sfd_pkg::KIND_PUSH, 6'd0, 16'sh0000, 16'shaaaa, 16'sh5555));
    offer(mk(sfd_pkg::KIND_LOAD, 6'd32, 16'sh5555, 16'sh0000, 16'sh0000));
    offer(mk(sfd_pkg::KIND_LOAD, 6'd1, 16'shaaaa, 16'sh0000, 16'sh0000));
    offer(mk(sfd_pkg::KIND_CLEAR, 6'd0, 16'sh0000, 16'sh0000, 16'sh0000));
    offer(mk(sfd_pkg::KIND_PUSH, 6'd0, 16'sh0000, 16'sh7fff, 16'sh8000));
    settle();

    // random phases; the first four pin the register extremes, the last
    // one runs with no idling on either side
    for (int p = 0; p < PHASES; p++) begin
      junk = '0;
      case (p)
        0: begin half = 6'd63; wide = 1'b1; scale = 4'd0;  stride = 4'd1;  end
        1: begin half = 6'd63; wide = 1'b0; scale = 4'd15; stride = 4'd15; end
        2: begin half = 6'd0;  wide = 1'b0; scale = 4'd0;  stride = 4'd0;  end
        3: begin half = 6'd32; wide = 1'b1; scale = 4'd15; stride = 4'd8;  end
        default: begin
          half   = 6'($urandom_range(0, 63));
          wide   = 1'($urandom);
          scale  = 4'($urandom_range(0, 15));
          stride = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 8));
          junk   = 6'($urandom);
        end
      endcase
      write_config(half, wide, scale, stride, junk);

      src_idling  = (p != 3) && (p != PHASES - 1);
      sink_idling = (p != 6) && (p != PHASES - 1);
      // every push emits at stride 1, so the hold-off backs the block up fast
      if (p == 0) hold_req = 1'b1;

      sent = 0;
      while (sent < PHASE_WORDS) begin
        w = random_word(counted);
        offer(w);
        maybe_gap();
        if (counted) sent++;
      end
      settle();
    end

    tracker.close();
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_in_if.sv
rtl/sfd_out_if.sv
rtl/sfd_cfg_if.sv
rtl/sfd_ram.sv
rtl/sfd_cell.sv
rtl/sfd_mac.sv
rtl/symmetric_iq_fir_decimator.sv
verif/tb_symmetric_iq_fir_decimator.sv
